### rtl/gppf_pkg.sv
`timescale 1ns / 1ps

package gppf_pkg;

  // Store sizes
  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 20;
  localparam int MAX_LINES  = MAX_POINTS * (MAX_POINTS - 1) / 2;

  // Address and counter widths
  localparam int PT_AW  = $clog2(MAX_POINTS);
  localparam int LN_AW  = $clog2(MAX_LINES);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int LCNT_W = $clog2(MAX_LINES + 1);

  // Field widths fixed by the interface
  localparam int HELD_W    = 7;
  localparam int LIMIT_W   = 7;
  localparam int LIMIT_RST = 64;

  // Line coefficient widths: a and b are coordinate differences, c a difference of products
  localparam int COEF_W  = COORD_BITS + 1;
  localparam int PROD_W  = COEF_W + COORD_BITS;
  localparam int CONST_W = PROD_W + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] cand_x;
    logic signed [COORD_BITS-1:0] cand_y;
  } gppf_req_t;

  typedef struct packed {
    logic                         accepted;
    logic signed [COORD_BITS-1:0] echo_x;
    logic signed [COORD_BITS-1:0] echo_y;
    logic [HELD_W-1:0]            points_held;
    logic                         done_res;
  } gppf_res_t;

  // Controller to datapath
  typedef struct packed {
    logic              cand_ld;
    logic              hit_clr;
    logic              scan_pv;
    logic              scan_lv;
    logic              app_v;
    logic [PT_AW-1:0]  pt_addr;
    logic [LN_AW-1:0]  ln_rd_addr;
    logic [LN_AW-1:0]  ln_wr_addr;
    logic              pt_wr;
    logic [PT_AW-1:0]  pt_wr_addr;
    logic              out_ld;
    logic              out_acc;
    logic [HELD_W-1:0] out_held;
    logic              out_done;
  } gppf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
  } gppf_sts_t;

endpackage

### rtl/gppf_ctrl.sv
`timescale 1ns / 1ps

module gppf_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  output logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            cfg_wr_en,
  input  logic [gppf_pkg::LIMIT_W-1:0]    cfg_wr_data,
  input  gppf_pkg::gppf_sts_t             sts,
  output gppf_pkg::gppf_cmd_t             cmd
);
  import gppf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_SDRAIN,
    ST_APPEND,
    ST_ADRAIN,
    ST_FINISH
  } state_t;

  state_t              state_r;
  logic [LIMIT_W-1:0]  limit_r;
  logic [CNT_W-1:0]    pc_r;
  logic [LCNT_W-1:0]   lc_r;
  logic [LCNT_W-1:0]   k_r;
  logic [1:0]          drain_r;
  logic                acc_r;
  logic                out_valid_r;

  logic [CNT_W-1:0]    lim;
  logic                full;
  logic [LCNT_W-1:0]   pc_ext;
  logic [LCNT_W-1:0]   scan_len;
  logic                scan_last;
  logic                app_last;
  logic                take_first;
  logic                take_scanned;

  // Clamp the limit to the store size
  always_comb begin
    if (int'(limit_r) > MAX_POINTS) begin
      lim = CNT_W'(MAX_POINTS);
    end else begin
      lim = CNT_W'(limit_r);
    end
  end

  assign full     = (pc_r >= lim);
  assign pc_ext   = LCNT_W'(pc_r);
  assign scan_len = (lc_r > pc_ext) ? lc_r : pc_ext;
  assign scan_last = (k_r == scan_len - LCNT_W'(1));
  assign app_last  = (k_r == pc_ext - LCNT_W'(1));

  // Accept paths: empty store, or a scan that found no hit
  assign take_first   = (state_r == ST_CHECK) && !full && (pc_r == '0);
  assign take_scanned = (state_r == ST_SDRAIN) && (drain_r == '0) && !sts.hit;

  // Drive datapath commands
  always_comb begin
    cmd            = '0;
    cmd.cand_ld    = in_valid && (state_r == ST_IDLE);
    cmd.hit_clr    = cmd.cand_ld;
    cmd.scan_pv    = (state_r == ST_SCAN) && (k_r < pc_ext);
    cmd.scan_lv    = (state_r == ST_SCAN) && (k_r < lc_r);
    cmd.app_v      = (state_r == ST_APPEND);
    cmd.pt_addr    = k_r[PT_AW-1:0];
    cmd.ln_rd_addr = k_r[LN_AW-1:0];
    cmd.ln_wr_addr = LN_AW'(lc_r + k_r);
    cmd.pt_wr      = take_first || take_scanned;
    cmd.pt_wr_addr = pc_r[PT_AW-1:0];
    cmd.out_ld     = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);
    cmd.out_acc    = acc_r;
    cmd.out_held   = HELD_W'(pc_r);
    cmd.out_done   = full;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= LIMIT_W'(LIMIT_RST);
      pc_r        <= '0;
      lc_r        <= '0;
      k_r         <= '0;
      drain_r     <= '0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end

      // Drop a taken result, load a finished one
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (full) begin
            acc_r   <= 1'b0;
            state_r <= ST_FINISH;
          end else if (pc_r == '0) begin
            acc_r   <= 1'b1;
            pc_r    <= pc_r + CNT_W'(1);
            state_r <= ST_FINISH;
          end else begin
            k_r     <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          k_r <= k_r + LCNT_W'(1);
          if (scan_last) begin
            drain_r <= 2'd3;
            state_r <= ST_SDRAIN;
          end
        end
        ST_SDRAIN: begin
          if (drain_r != '0) begin
            drain_r <= drain_r - 2'd1;
          end else if (sts.hit) begin
            acc_r   <= 1'b0;
            state_r <= ST_FINISH;
          end else begin
            acc_r   <= 1'b1;
            k_r     <= '0;
            state_r <= ST_APPEND;
          end
        end
        ST_APPEND: begin
          k_r <= k_r + LCNT_W'(1);
          if (app_last) begin
            drain_r <= 2'd3;
            state_r <= ST_ADRAIN;
          end
        end
        ST_ADRAIN: begin
          if (drain_r != '0) begin
            drain_r <= drain_r - 2'd1;
          end else begin
            lc_r    <= lc_r + pc_ext;
            pc_r    <= pc_r + CNT_W'(1);
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (cmd.out_ld) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_line_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (int'(lc_r) == int'(pc_r) * (int'(pc_r) - 1) / 2))
    else $error("line count out of step with point count");

  a_append_bump: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADRAIN && drain_r == '0) |=> (int'(pc_r) == int'($past(pc_r)) + 1))
    else $error("append did not add one point");

  a_line_addr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.app_v |-> (int'(lc_r) + int'(k_r) < MAX_LINES))
    else $error("line write beyond store");
`endif

endmodule

### rtl/gppf_dp.sv
`timescale 1ns / 1ps

module gppf_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gppf_pkg::gppf_req_t  in_req,
  input  gppf_pkg::gppf_cmd_t  cmd,
  output gppf_pkg::gppf_sts_t  sts,
  output gppf_pkg::gppf_res_t  out_res
);
  import gppf_pkg::*;

  typedef struct packed {
    logic signed [COEF_W-1:0]  a;
    logic signed [COEF_W-1:0]  b;
    logic signed [CONST_W-1:0] c;
  } line_t;

  gppf_req_t pt_mem [MAX_POINTS];
  line_t     ln_mem [MAX_LINES];

  gppf_req_t cand_r;
  gppf_req_t pt_q_r;
  line_t     ln_q_r;
  gppf_res_t out_res_r;

  // Stage valids
  logic s1_pv_r, s1_lv_r, s1_app_r;
  logic s2_lv_r, s2_app_r;
  logic s3_lv_r, s3_app_r;
  logic hit_r;

  logic [LN_AW-1:0] wa1_r, wa2_r, wa3_r;

  logic signed [COEF_W-1:0]     op0_r, op1_r;
  logic signed [CONST_W-1:0]    c2_r, c3_r;
  logic signed [PROD_W-1:0]     p0_r, p1_r;
  logic signed [COEF_W-1:0]     na3_r, b3_r;

  logic signed [COEF_W-1:0]     dx, dy;
  logic signed [COORD_BITS-1:0] m0, m1;
  logic signed [PROD_W-1:0]     p0, p1;
  logic signed [CONST_W-1:0]    sum, diff;
  logic                         pt_hit, ln_hit;
  line_t                        ln_wr;

  // Hold the candidate
  always_ff @(posedge clk) begin
    if (cmd.cand_ld) begin
      cand_r <= in_req;
    end
  end

  // Point store
  always_ff @(posedge clk) begin
    if (cmd.pt_wr) begin
      pt_mem[cmd.pt_wr_addr] <= cand_r;
    end
    if (cmd.scan_pv || cmd.app_v) begin
      pt_q_r <= pt_mem[cmd.pt_addr];
    end
  end

  // Line store
  always_ff @(posedge clk) begin
    if (s3_app_r) begin
      ln_mem[wa3_r] <= ln_wr;
    end
    if (cmd.scan_lv) begin
      ln_q_r <= ln_mem[cmd.ln_rd_addr];
    end
  end

  // Differences from the stored point
  assign dx = {pt_q_r.cand_x[COORD_BITS-1], pt_q_r.cand_x}
            - {cand_r.cand_x[COORD_BITS-1], cand_r.cand_x};
  assign dy = {pt_q_r.cand_y[COORD_BITS-1], pt_q_r.cand_y}
            - {cand_r.cand_y[COORD_BITS-1], cand_r.cand_y};

  // Shared multipliers: a*x and b*y on a scan, dx*y and dy*x on an append
  assign m0 = s2_app_r ? cand_r.cand_y : cand_r.cand_x;
  assign m1 = s2_app_r ? cand_r.cand_x : cand_r.cand_y;
  assign p0 = op0_r * m0;
  assign p1 = op1_r * m1;

  assign sum  = p0_r + p1_r;
  assign diff = p0_r - p1_r;

  assign pt_hit = s1_pv_r && (pt_q_r == cand_r);
  assign ln_hit = s3_lv_r && (sum == c3_r);

  assign ln_wr.a = na3_r;
  assign ln_wr.b = b3_r;
  assign ln_wr.c = diff;

  // Advance the operand pipeline
  always_ff @(posedge clk) begin
    wa1_r <= cmd.ln_wr_addr;
    wa2_r <= wa1_r;
    wa3_r <= wa2_r;
    op0_r <= s1_app_r ? dx : ln_q_r.a;
    op1_r <= s1_app_r ? dy : ln_q_r.b;
    c2_r  <= ln_q_r.c;
    p0_r  <= p0;
    p1_r  <= p1;
    c3_r  <= c2_r;
    na3_r <= -op1_r;
    b3_r  <= op0_r;
  end

  // Stage valids and the sticky hit flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_pv_r  <= 1'b0;
      s1_lv_r  <= 1'b0;
      s1_app_r <= 1'b0;
      s2_lv_r  <= 1'b0;
      s2_app_r <= 1'b0;
      s3_lv_r  <= 1'b0;
      s3_app_r <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      s1_pv_r  <= cmd.scan_pv;
      s1_lv_r  <= cmd.scan_lv;
      s1_app_r <= cmd.app_v;
      s2_lv_r  <= s1_lv_r;
      s2_app_r <= s1_app_r;
      s3_lv_r  <= s2_lv_r;
      s3_app_r <= s2_app_r;
      if (cmd.hit_clr) begin
        hit_r <= 1'b0;
      end else if (pt_hit || ln_hit) begin
        hit_r <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_res_r.accepted    <= cmd.out_acc;
      out_res_r.echo_x      <= cand_r.cand_x;
      out_res_r.echo_y      <= cand_r.cand_y;
      out_res_r.points_held <= cmd.out_held;
      out_res_r.done_res    <= cmd.out_done;
    end
  end

  assign sts.hit = hit_r;
  assign out_res = out_res_r;

endmodule

### rtl/general_position_point_filter.sv
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// in        in_valid / in_stall     in_req  (cand_x, cand_y)
// out       out_valid / out_stall   out_res (accepted, echo_x, echo_y, points_held, done_res)
// cfg       cfg_wr_en               cfg_wr_data (point_limit)
//
// One request at a time. An accepted candidate with P >= 1 stored points and L stored
// lines goes through a scan with one stored entry checked per cycle, a drain, an append
// pass with one new line built per cycle through the shared pair of multipliers, and a
// drain. A rejected request skips the append pass; an empty or full store skips both passes.
// Reset (rst_n low, synchronous) empties both stores and sets the limit to 64.
// A result waits in the output register under out_stall while the next request is taken.

module general_position_point_filter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  gppf_pkg::gppf_req_t          in_req,
  output logic                         out_valid,
  input  logic                         out_stall,
  output gppf_pkg::gppf_res_t          out_res,
  input  logic                         cfg_wr_en,
  input  logic [gppf_pkg::LIMIT_W-1:0] cfg_wr_data
);
  import gppf_pkg::*;

  gppf_cmd_t cmd;
  gppf_sts_t sts;

  gppf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sts         (sts),
    .cmd         (cmd)
  );

  gppf_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .sts     (sts),
    .out_res (out_res)
  );

endmodule

### bench/tb_general_position_point_filter.sv
`timescale 1ns / 1ps

module tb_general_position_point_filter;
  import gppf_pkg::*;

  localparam longint COORD_MIN = -(longint'(1) << (COORD_BITS - 1));
  localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  gppf_req_t           in_req = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  gppf_res_t           out_res;
  logic                cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0]  cfg_wr_data = '0;

  // Shadow store of accepted points and lines through every accepted pair
  longint held_x [MAX_POINTS];
  longint held_y [MAX_POINTS];
  longint line_a [MAX_LINES];
  longint line_b [MAX_LINES];
  longint line_c [MAX_LINES];
  int     held_count = 0;
  int     line_count = 0;
  int     limit_reg = LIMIT_RST;

  gppf_res_t judged_q[$];
  int        mismatch_count = 0;
  bit        sender_steady = 1'b1;
  int        burst_left = 0;
  int        stall_mode = 0;
  int        stall_run = 0;

  general_position_point_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  // Judge one candidate against the shadow store and update it
  function automatic gppf_res_t judge_point(gppf_req_t req);
    longint    x, y, dx, dy;
    int        lim, i;
    bit        ok;
    gppf_res_t res;
    x = req.cand_x;
    y = req.cand_y;
    lim = (limit_reg > MAX_POINTS) ? MAX_POINTS : limit_reg;
    ok = (held_count < lim);
    for (i = 0; ok && i < held_count; i++)
      if (held_x[i] == x && held_y[i] == y) ok = 1'b0;
    for (i = 0; ok && i < line_count; i++)
      if (line_a[i] * x + line_b[i] * y == line_c[i]) ok = 1'b0;
    if (ok) begin
      // Append the lines through the new point and each earlier one
      for (i = 0; i < held_count; i++) begin
        dx = held_x[i] - x;
        dy = held_y[i] - y;
        line_a[line_count] = -dy;
        line_b[line_count] = dx;
        line_c[line_count] = dx * y - dy * x;
        line_count++;
      end
      held_x[held_count] = x;
      held_y[held_count] = y;
      held_count++;
    end
    res.accepted    = ok;
    res.echo_x      = req.cand_x;
    res.echo_y      = req.cand_y;
    res.points_held = held_count[HELD_W-1:0];
    res.done_res    = (held_count >= lim);
    return res;
  endfunction

  function automatic gppf_req_t make_req(longint x, longint y);
    gppf_req_t r;
    r.cand_x = x[COORD_BITS-1:0];
    r.cand_y = y[COORD_BITS-1:0];
    return r;
  endfunction

  function automatic longint gcd(longint a, longint b);
    longint t;
    if (a < 0) a = -a;
    if (b < 0) b = -b;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Pick a point on the line through two stored points; fall back to a repeat
  function automatic gppf_req_t collinear_req();
    int     i, j;
    longint dx, dy, g, k, x, y;
    i = $urandom_range(0, held_count - 1);
    do j = $urandom_range(0, held_count - 1); while (j == i);
    dx = held_x[j] - held_x[i];
    dy = held_y[j] - held_y[i];
    g = gcd(dx, dy);
    k = longint'($urandom_range(0, 12)) - 6;
    x = held_x[i] + k * (dx / g);
    y = held_y[i] + k * (dy / g);
    if (x < COORD_MIN || x > COORD_MAX || y < COORD_MIN || y > COORD_MAX) begin
      x = held_x[i];
      y = held_y[i];
    end
    return make_req(x, y);
  endfunction

  function automatic longint extreme_coord();
    case ($urandom_range(0, 3))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d (time %0t)", what, got, want, $time);
    mismatch_count++;
  endtask

  // Send one request, idling between bursts unless the sender is steady
  task automatic send_candidate(input gppf_req_t req);
    if (!sender_steady && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    if (burst_left > 0) burst_left--;
    in_req   <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    judged_q.push_back(judge_point(req));
  endtask

  // Hold off new requests until every expected result has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (judged_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input int value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[LIMIT_W-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limit_reg = value & 'h7F;
  endtask

  task automatic test_limit_zero();
    write_limit(0);
    send_candidate(make_req(5, -3));
    send_candidate(make_req(COORD_MIN, COORD_MAX));
  endtask

  task automatic test_limit_one();
    write_limit(1);
    send_candidate(make_req(COORD_MIN, COORD_MAX));
    send_candidate(make_req(7, 7));
  endtask

  task automatic test_lone_repeat();
    write_limit(64);
    send_candidate(make_req(COORD_MIN, COORD_MAX));
  endtask

  task automatic test_extreme_lines();
    send_candidate(make_req(COORD_MAX, COORD_MIN));
    send_candidate(make_req(0, -1));
    send_candidate(make_req(-1, 0));
    send_candidate(make_req(0, 0));
    send_candidate(make_req(COORD_MAX, COORD_MAX));
    send_candidate(make_req(COORD_MIN, COORD_MIN));
    send_candidate(make_req(COORD_MAX, COORD_MIN));
  endtask

  task automatic test_limit_above_capacity();
    write_limit(127);
    send_candidate(make_req(3, 11));
  endtask

  task automatic test_limit_below_count();
    write_limit(2);
    send_candidate(make_req(-100, 250));
    send_candidate(make_req(COORD_MIN, 0));
  endtask

  // Mix fresh points with collinear points, repeats and extremes
  task automatic test_random_candidates(input int lim, input int count, input bit steady);
    logic [31:0] rx, ry;
    int          pick;
    gppf_req_t   req;
    write_limit(lim);
    sender_steady = steady;
    for (int n = 0; n < count; n++) begin
      rx = $urandom();
      ry = $urandom();
      pick = $urandom_range(0, 99);
      req.cand_x = rx[COORD_BITS-1:0];
      req.cand_y = ry[COORD_BITS-1:0];
      if (pick >= 30 && pick < 50)
        req = make_req(longint'($urandom_range(0, 16)) - 8,
                       longint'($urandom_range(0, 16)) - 8);
      else if (pick >= 50 && pick < 75 && held_count >= 2)
        req = collinear_req();
      else if (pick >= 75 && pick < 88 && held_count >= 1) begin
        pick = $urandom_range(0, held_count - 1);
        req = make_req(held_x[pick], held_y[pick]);
      end else if (pick >= 88)
        req = make_req(extreme_coord(), extreme_coord());
      if ($urandom_range(0, 19) == 0) wait_drained();
      send_candidate(req);
    end
  endtask

  // Stall the result channel in stretches of varying density
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_run  <= $urandom_range(5, 60);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    gppf_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (judged_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = judged_q.pop_front();
        if (out_res.accepted !== want.accepted)
          report_mismatch("accepted", out_res.accepted, want.accepted);
        if (out_res.echo_x !== want.echo_x)
          report_mismatch("echo_x", longint'(out_res.echo_x), longint'(want.echo_x));
        if (out_res.echo_y !== want.echo_y)
          report_mismatch("echo_y", longint'(out_res.echo_y), longint'(want.echo_y));
        if (out_res.points_held !== want.points_held)
          report_mismatch("points_held", out_res.points_held, want.points_held);
        if (out_res.done_res !== want.done_res)
          report_mismatch("done_res", out_res.done_res, want.done_res);
      end
    end
  end

  initial begin
    #20000000;
    $display("tb_general_position_point_filter NOT OK");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_limit_zero();
    test_limit_one();
    test_lone_repeat();
    test_extreme_lines();
    test_limit_above_capacity();
    test_limit_below_count();
    test_random_candidates(16, 60, 1'b0);
    test_random_candidates(40, 80, 1'b1);
    test_random_candidates(127, 90, 1'b0);
    test_random_candidates(64, 20, 1'b1);
    test_random_candidates(5, 20, 1'b0);

    // Drain, then watch for stray results over one worst-case step
    wait_drained();
    repeat (2200) @(posedge clk);
    if (mismatch_count == 0 && judged_q.size() == 0) begin
      $display("tb_general_position_point_filter OK");
    end else begin
      $display("tb_general_position_point_filter NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/gppf_pkg.sv
rtl/gppf_ctrl.sv
rtl/gppf_dp.sv
rtl/general_position_point_filter.sv
bench/tb_general_position_point_filter.sv
